// File: rtl/core/krc_pkg.sv
`timescale 1ns / 1ps

package krc_pkg;

  // Default configuration of the counter.
  localparam int KmerLengthDef = 8;
  localparam int CountBitsDef  = 8;

  // The rolling key spans the newest eight bases; shorter k-mers use only 2*K bits.
  localparam int KeyW        = 16;
  localparam int StoreDepth  = 65536;
  localparam int StoreAddrW  = $clog2(StoreDepth);

  localparam int ThreshW     = 8;
  localparam logic [ThreshW-1:0] ThreshReset = 8'd24;

  localparam int OccW        = 8;

endpackage

// File: rtl/core/krc_ram.sv
`timescale 1ns / 1ps

module krc_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Read-first; read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/kmer_repeat_counter.sv
`timescale 1ns / 1ps

// An accepted base is registered in stage 1, then in the output register.
// Throughput: one base per cycle while no clear sweep or stall holds off the input;
// the count read-modify-write is one RAM read, an increment and a write-back, with
// the previous write forwarded. Reset: async, active low. After reset the count
// store is swept to zero, one entry per cycle; bases are held off meanwhile.
module kmer_repeat_counter #(
  parameter int KMER_LENGTH = krc_pkg::KmerLengthDef,
  parameter int COUNT_BITS  = krc_pkg::CountBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [krc_pkg::ThreshW-1:0] cfg_data_i,
  // base stream
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  base_code_i,
  input  logic                        unknown_base_i,
  input  logic                        sequence_start_i,
  // result stream
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [krc_pkg::KeyW-1:0]    kmer_key_o,
  output logic                        key_valid_o,
  output logic [krc_pkg::OccW-1:0]    occurrence_count_o,
  output logic                        newly_repetitive_o
);

  import krc_pkg::*;

  // Short k-mers keep only 2*K key bits.
  localparam int KeyBits = (KMER_LENGTH >= 8) ? KeyW : 2 * KMER_LENGTH;
  localparam logic [KeyW-1:0] KeyMask = KeyW'((64'd1 << KeyBits) - 64'd1);
  localparam int RunW = $clog2(KMER_LENGTH + 1);
  localparam logic [RunW-1:0] RunFull = RunW'(KMER_LENGTH);
  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};
  // compare width that holds both a count and threshold + 1
  localparam int CmpW = (COUNT_BITS > ThreshW + 1) ? COUNT_BITS : ThreshW + 1;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [ThreshW-1:0] thresh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thresh_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Clearing sweep over the count store
  // ---------------------------------------------------------------------------
  logic                  clr_active_q;
  logic [StoreAddrW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_active_q <= 1'b1;
      clr_addr_q   <= '0;
    end else if (clr_active_q) begin
      clr_addr_q <= clr_addr_q + StoreAddrW'(1);
      if (clr_addr_q == {StoreAddrW{1'b1}}) begin
        clr_active_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake / pipeline control
  // ---------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_fire;
  logic in_fire;

  // Stage 1 moves into the output register when that register is free or drains.
  assign s1_fire    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_active_q || (s1_valid_q && !s1_fire);
  assign in_fire    = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------------
  // Stage 0: rolling key and clean run
  // ---------------------------------------------------------------------------
  logic [KeyW-1:0] key_q, key_d;
  logic [RunW-1:0] run_q, run_d, run_base;
  logic            key_ok;

  always_comb begin
    run_base = sequence_start_i ? '0 : run_q;
    if (unknown_base_i) begin
      key_d = (key_q << 2) & KeyMask;
      run_d = '0;
    end else begin
      key_d = ((key_q << 2) | KeyW'(base_code_i)) & KeyMask;
      run_d = (run_base < RunFull) ? run_base + RunW'(1) : run_base;
    end
    key_ok = (run_d == RunFull);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      run_q <= '0;
    end else if (in_fire) begin
      key_q <= key_d;
      run_q <= run_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: count read-modify-write
  // ---------------------------------------------------------------------------
  logic [KeyW-1:0]       s1_key_q;
  logic                  s1_ok_q;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic                  ram_we;
  logic [StoreAddrW-1:0] ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;

  // last write to the store, forwarded to a read issued in the same cycle
  logic                  wr_valid_q;
  logic [KeyW-1:0]       wr_addr_q;
  logic [COUNT_BITS-1:0] wr_data_q;

  logic [COUNT_BITS-1:0] cnt_cur, cnt_new;
  logic                  cnt_sat;
  logic                  cnt_wr;
  logic                  newly;

  always_comb begin
    cnt_cur = (wr_valid_q && (wr_addr_q == s1_key_q)) ? wr_data_q : ram_rdata;
    cnt_sat = (cnt_cur == CountMax);
    cnt_new = cnt_sat ? cnt_cur : cnt_cur + COUNT_BITS'(1);
    cnt_wr  = s1_fire && s1_ok_q && !cnt_sat;
    newly   = s1_ok_q && !cnt_sat &&
              (CmpW'(cnt_new) == (CmpW'(thresh_q) + CmpW'(1)));
  end

  always_comb begin
    if (clr_active_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = cnt_wr;
      ram_waddr = StoreAddrW'(s1_key_q);
      ram_wdata = cnt_new;
    end
  end

  krc_ram #(
    .Width (COUNT_BITS),
    .Depth (StoreDepth)
  ) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_fire && key_ok),
    .raddr_i (StoreAddrW'(key_d)),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wr_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (cnt_wr) begin
        wr_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_key_q <= key_d;
      s1_ok_q  <= key_ok;
    end
    if (cnt_wr) begin
      wr_addr_q <= s1_key_q;
      wr_data_q <= cnt_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [KeyW-1:0] out_key_q;
  logic            out_ok_q;
  logic [OccW-1:0] out_cnt_q;
  logic            out_newly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_key_q   <= s1_key_q;
      out_ok_q    <= s1_ok_q;
      out_cnt_q   <= s1_ok_q ? OccW'(cnt_new) : '0;
      out_newly_q <= newly;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kmer_key_o         = out_key_q;
  assign key_valid_o        = out_ok_q;
  assign occurrence_count_o = out_cnt_q;
  assign newly_repetitive_o = out_newly_q;

endmodule

// File: test/kmer_count_checker.sv
`timescale 1ns / 1ps

// Watches config writes, accepted bases and result beats of kmer_repeat_counter.
// Keeps its own rolling key, run length and count table, and compares each
// result beat with the oldest predicted one.
module kmer_count_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [krc_pkg::ThreshW-1:0] cfg_data_i,
  input  logic                        in_valid_i,
  input  logic                        in_stall_i,
  input  logic [1:0]                  base_code_i,
  input  logic                        unknown_base_i,
  input  logic                        sequence_start_i,
  input  logic                        out_valid_i,
  input  logic                        out_stall_i,
  input  logic [krc_pkg::KeyW-1:0]    kmer_key_i,
  input  logic                        key_valid_i,
  input  logic [krc_pkg::OccW-1:0]    occurrence_count_i,
  input  logic                        newly_repetitive_i,
  output int                          fail_count_o,
  output int                          pending_o
);

  import krc_pkg::*;

  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            key_valid;
    logic [OccW-1:0] occ;
    logic            newly;
  } kmer_result_t;

  localparam longint CountMax = (64'd1 << CountBitsDef) - 1;
  localparam logic [KeyW-1:0] KeyMask = (2 * KmerLengthDef >= KeyW) ? '1 :
                                        KeyW'((1 << (2 * KmerLengthDef)) - 1);
  localparam int PrintCap = 40;

  logic [KeyW-1:0]         window;
  int                      run_len;
  logic [ThreshW-1:0]      threshold;
  logic [CountBitsDef-1:0] occ_table [StoreDepth];
  kmer_result_t            result_q [$];

  // Shift one base into the window and bump its count when the key is complete.
  function automatic kmer_result_t count_base(logic [1:0] code, logic unk, logic start);
    kmer_result_t            r;
    logic [CountBitsDef-1:0] c;
    r = '0;
    if (start) run_len = 0;
    if (unk) begin
      window  = (window << 2) & KeyMask;
      run_len = 0;
    end else begin
      window = ((window << 2) | code) & KeyMask;
      if (run_len < KmerLengthDef) run_len++;
    end
    r.key       = window;
    r.key_valid = (run_len >= KmerLengthDef);
    if (r.key_valid) begin
      c = occ_table[window];
      if (longint'(c) < CountMax) begin
        c++;
        occ_table[window] = c;
        r.newly = (longint'(c) == longint'(threshold) + 1);
      end
      r.occ = OccW'(c);
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    if (fail_count_o < PrintCap) $display("[%0t] kmer checker: %s", $time, msg);
    fail_count_o++;
  endtask

  task automatic check_beat();
    kmer_result_t want;
    if (result_q.size() == 0) begin
      report_mismatch($sformatf("result beat with no base pending, key %h", kmer_key_i));
    end else begin
      want = result_q.pop_front();
      if (kmer_key_i !== want.key)
        report_mismatch($sformatf("kmer_key got %h want %h", kmer_key_i, want.key));
      if (key_valid_i !== want.key_valid)
        report_mismatch($sformatf("key_valid got %b want %b (key %h)",
                                  key_valid_i, want.key_valid, want.key));
      if (occurrence_count_i !== want.occ)
        report_mismatch($sformatf("occurrence_count got %0d want %0d (key %h)",
                                  occurrence_count_i, want.occ, want.key));
      if (newly_repetitive_i !== want.newly)
        report_mismatch($sformatf("newly_repetitive got %b want %b (key %h)",
                                  newly_repetitive_i, want.newly, want.key));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window    = '0;
      run_len   = 0;
      threshold = ThreshReset;
      foreach (occ_table[i]) occ_table[i] = '0;
      result_q.delete();
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) threshold = cfg_data_i;
      if (in_valid_i && !in_stall_i)
        result_q.push_back(count_base(base_code_i, unknown_base_i, sequence_start_i));
      if (out_valid_i && !out_stall_i) check_beat();
      pending_o = result_q.size();
    end
  end

endmodule

// File: test/tb_kmer_repeat_counter.sv
`timescale 1ns / 1ps

// Top of the kmer_repeat_counter bench: clock, reset, base stream, result sink
// and threshold writes. Checking of result beats lives in kmer_count_checker.
module tb_kmer_repeat_counter;
  import krc_pkg::*;

  // Watchdog bound: the clear sweep and ~900 bases with gaps and stalls stay far below.
  localparam int CycleLimit   = 600_000;
  // Short settle margin once every result beat is back.
  localparam int SettleCycles = 4;
  // Long receiver hold-off, enough to back the pipe up into the input side.
  localparam int HoldCycles   = 80;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [ThreshW-1:0] cfg_data  = '0;

  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [1:0] base_code = 2'd0;
  logic       unknown   = 1'b0;
  logic       seq_start = 1'b0;

  logic            out_valid;
  logic            out_stall = 1'b0;
  logic [KeyW-1:0] kmer_key;
  logic            key_valid;
  logic [OccW-1:0] occ_count;
  logic            newly_rep;

  int fail_count;
  int pending;
  int cycles = 0;

  bit hold_req  = 1'b0;  // ask the sink for one long hold-off
  bit steady    = 1'b0;  // sender offers back to back, no gaps
  bit nogap_seq = 1'b0;  // current sequence goes out without gaps

  always #1 clk = ~clk;

  kmer_repeat_counter dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .base_code_i        (base_code),
    .unknown_base_i     (unknown),
    .sequence_start_i   (seq_start),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .kmer_key_o         (kmer_key),
    .key_valid_o        (key_valid),
    .occurrence_count_o (occ_count),
    .newly_repetitive_o (newly_rep)
  );

  kmer_count_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_i        (cfg_ready),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .base_code_i        (base_code),
    .unknown_base_i     (unknown),
    .sequence_start_i   (seq_start),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .kmer_key_i         (kmer_key),
    .key_valid_i        (key_valid),
    .occurrence_count_i (occ_count),
    .newly_repetitive_i (newly_rep),
    .fail_count_o       (fail_count),
    .pending_o          (pending)
  );

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("kmer_repeat_counter test failed");
      $finish;
    end
  end

  // Mostly short idles, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result sink: stall in random bursts; on request, one long hold-off
  // while the sender keeps pushing.
  initial begin : result_sink
    int burst;
    bit level;
    burst = 0;
    level = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk);
        burst = 0;
      end else begin
        if (burst == 0) begin
          level = ($urandom_range(0, 2) == 0);
          burst = 1 + idle_len();
          if (!level) burst = burst * 3;  // longer stretches with no stall
        end
        out_stall <= level;
        burst--;
      end
    end
  end

  // One base beat; payload holds until accepted.
  task automatic send_base(logic [1:0] code, logic unk, logic start);
    int gap;
    gap = (steady || nogap_seq) ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid  <= 1'b1;
    base_code <= code;
    unknown   <= unk;
    seq_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Sender pause: drop valid and wait until every result beat is back.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Threshold is only written with the block idle.
  task automatic write_threshold(logic [ThreshW-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random sequences. Half are short repeated motifs so keys recur and counts
  // climb; the rest are plain random reads with a sprinkle of N, and noise with
  // frequent N and stray sequence starts.
  task automatic send_random(int total);
    int         sent;
    int         kind;
    int         len;
    int         period;
    logic [1:0] motif [4];
    logic [1:0] code;
    logic       unk;
    logic       start;
    sent = 0;
    while (sent < total) begin
      kind   = $urandom_range(0, 99);
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 20);
      period = $urandom_range(1, 4);
      foreach (motif[i]) motif[i] = 2'($urandom_range(0, 3));
      nogap_seq = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len && sent < total; i++) begin
        if (kind < 50) begin
          code  = motif[i % period];
          unk   = 1'b0;
          start = (i == 0);
        end else if (kind < 80) begin
          code  = 2'($urandom_range(0, 3));
          unk   = ($urandom_range(0, 19) == 0);
          start = (i == 0);
        end else begin
          code  = 2'($urandom_range(0, 3));
          unk   = ($urandom_range(0, 2) == 0);
          start = ($urandom_range(0, 7) == 0);
        end
        send_base(code, unk, start);
        sent++;
      end
    end
    nogap_seq = 1'b0;
  endtask

  initial begin : stimulus
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Directed, reset threshold. First key completes on the eighth clean base.
    send_base(2'd3, 1'b0, 1'b1);
    for (int i = 0; i < 7; i++) send_base(2'((i < 4) ? i : 6 - i), 1'b0, 1'b0);
    // N with a nonzero code: zero shifted in, run broken.
    send_base(2'd2, 1'b1, 1'b0);
    send_base(2'd1, 1'b0, 1'b0);
    // Start mid-run, then start together with N.
    send_base(2'd3, 1'b0, 1'b1);
    send_base(2'd0, 1'b1, 1'b1);
    // All-T refill: key FFFF becomes valid, then counts twice.
    repeat (9) send_base(2'd3, 1'b0, 1'b0);
    send_base(2'd0, 1'b0, 1'b1);

    // Threshold zero: every first occurrence is flagged.
    write_threshold(8'd0);
    send_random(120);

    // Top threshold: a long T run drives key FFFF to saturation; the flag
    // fires on the last increment only.
    write_threshold(8'd254);
    send_base(2'd3, 1'b0, 1'b1);
    repeat (275) send_base(2'd3, 1'b0, 1'b0);

    // Threshold at the count maximum: never flagged, saturated key revisited.
    write_threshold(8'hFF);
    send_base(2'd3, 1'b0, 1'b1);
    repeat (15) send_base(2'd3, 1'b0, 1'b0);
    send_random(80);

    // Threshold one, with one long sink hold-off while bases keep coming,
    // then a sender pause until everything is back.
    write_threshold(8'd1);
    send_random(60);
    hold_req = 1'b1;
    steady   = 1'b1;
    send_random(60);
    steady   = 1'b0;
    drain();
    send_random(80);

    write_threshold(8'($urandom_range(2, 30)));
    send_random(120);

    drain();
    repeat (SettleCycles) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("kmer_repeat_counter test passed");
    end else begin
      $display("kmer_repeat_counter test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/krc_pkg.sv
rtl/core/krc_ram.sv
rtl/core/kmer_repeat_counter.sv
test/kmer_count_checker.sv
test/tb_kmer_repeat_counter.sv
